@@ hdl/rational_arithmetic_unit_top_macros.svh @@
// ----------------------------------------------------------------------------
// rational_arithmetic_unit_top_macros
// assertion macros for the rational arithmetic unit
// ----------------------------------------------------------------------------
`ifndef RATIONAL_ARITHMETIC_UNIT_TOP_MACROS_SVH
`define RATIONAL_ARITHMETIC_UNIT_TOP_MACROS_SVH

// implication checked on every clock edge outside reset
`define RAU_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// implication with the consequent checked in the cycle after the antecedent
`define RAU_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hdl/rau_pkg.sv @@
// ----------------------------------------------------------------------------
// rau_pkg
// shared types and constants of the rational arithmetic unit
// ----------------------------------------------------------------------------
package rau_pkg;
   localparam int unsigned WordWidth = 64;
   localparam logic [2:0] CmdAdd = 3'd0;
   localparam logic [2:0] CmdSub = 3'd1;
   localparam logic [2:0] CmdMul = 3'd2;
   localparam logic [2:0] CmdDiv = 3'd3;
   localparam logic [2:0] CmdCmp = 3'd4;

   // request to and status from the shared divider
   typedef struct packed {
      logic start;
      logic [WordWidth-1:0] dividend;
      logic [WordWidth-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic busy;
      logic done;
      logic [WordWidth-1:0] quot;
      logic [WordWidth-1:0] rem;
   } div_rsp_type;
endpackage

@@ hdl/rational_arithmetic_unit_top.sv @@
// ----------------------------------------------------------------------------
// rational_arithmetic_unit_top
// fraction add, subtract, multiply, divide and compare with gcd reduction
// ----------------------------------------------------------------------------
// One word in, one word out. The block takes a command and two fractions,
// forms the cross products on one shared 32x32 multiplier, reduces the result
// by a signed Euclid loop and then divides numerator and denominator by the
// gcd. All remainders and quotients run on one shared radix-2 divider, and
// each euclid step is followed by a zero check of the new remainder.
// Compare finishes after the cross products, and division by a zero
// fraction or an unknown command after the first product, without the
// divider; arithmetic runs the euclid loop and the two final divisions.
// req_ready is low while an item is in work; a finished word sits in its own
// output register, and a new result waits for that register to free up.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit_top #(
   parameter int OPERAND_WIDTH = 32
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  logic [2:0] req_command,
   input  logic signed [31:0] req_a_num,
   input  logic signed [31:0] req_a_den,
   input  logic signed [31:0] req_b_num,
   input  logic signed [31:0] req_b_den,
   output logic rsp_valid,
   input  logic rsp_ready,
   output logic signed [63:0] rsp_res_num,
   output logic signed [63:0] rsp_res_den,
   output logic rsp_div_zero,
   output logic rsp_is_equal,
   output logic rsp_is_less,
   output logic rsp_is_greater
);
   import rau_pkg::*;

   // divider request and status between sequencer and divider
   div_req_type dreq;
   div_rsp_type drsp;

   rau_sequencer #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_seq (
      .clock, .reset, .req_valid, .req_ready, .req_command,
      .req_a_num, .req_a_den, .req_b_num, .req_b_den,
      .rsp_valid, .rsp_ready, .rsp_res_num, .rsp_res_den, .rsp_div_zero,
      .rsp_is_equal, .rsp_is_less, .rsp_is_greater,
      .dreq, .drsp
   );

   // shared divider for euclid remainders and final quotients
   rau_divider u_div (.clock, .reset, .req(dreq), .rsp(drsp));
endmodule

@@ hdl/rau_divider.sv @@
// ----------------------------------------------------------------------------
// rau_divider
// radix-2 truncating signed divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`include "rational_arithmetic_unit_top_macros.svh"
module rau_divider (
   input  logic clock,
   input  logic reset,
   input  rau_pkg::div_req_type req,
   output rau_pkg::div_rsp_type rsp
);
   import rau_pkg::*;

   typedef enum logic [1:0] {S_IDLE, S_RUN, S_DONE} state_type;

   state_type state_ff;
   logic [6:0] count_ff;
   logic [WordWidth-1:0] rem_ff, quot_ff, dvs_ff;
   logic qneg_ff, rneg_ff;
   logic [WordWidth:0] trial;
   logic [WordWidth-1:0] rshift;

   assign rshift = {rem_ff[WordWidth-2:0], quot_ff[WordWidth-1]};
   assign trial  = {1'b0, rshift} - {1'b0, dvs_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (req.start) begin
                  rem_ff   <= '0;
                  quot_ff  <= req.dividend[WordWidth-1] ? -req.dividend : req.dividend;
                  dvs_ff   <= req.divisor[WordWidth-1] ? -req.divisor : req.divisor;
                  qneg_ff  <= req.dividend[WordWidth-1] ^ req.divisor[WordWidth-1];
                  rneg_ff  <= req.dividend[WordWidth-1];
                  count_ff <= 7'(WordWidth);
                  state_ff <= S_RUN;
               end
            end
            S_RUN: begin
               // the dropped top bit of rem_ff is zero since rem < divisor <= 2^63
               if (!trial[WordWidth] || rem_ff[WordWidth-1]) begin
                  rem_ff <= trial[WordWidth-1:0];
                  quot_ff <= {quot_ff[WordWidth-2:0], 1'b1};
               end else begin
                  rem_ff <= rshift;
                  quot_ff <= {quot_ff[WordWidth-2:0], 1'b0};
               end
               count_ff <= count_ff - 7'd1;
               if (count_ff == 7'd1) state_ff <= S_DONE;
            end
            S_DONE: begin
               quot_ff  <= qneg_ff ? -quot_ff : quot_ff;
               rem_ff   <= rneg_ff ? -rem_ff : rem_ff;
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   logic done_ff;
   always_ff @(posedge clock) begin
      if (reset) done_ff <= 1'b0;
      else done_ff <= (state_ff == S_DONE);
   end

   assign rsp.busy = (state_ff != S_IDLE);
   assign rsp.done = done_ff;
   assign rsp.quot = quot_ff;
   assign rsp.rem  = rem_ff;

   `RAU_ASSERT_NEXT(a_div_done, clock, reset, state_ff == S_DONE, done_ff, "divider done lost")
   `RAU_ASSERT_IMP(a_div_cnt, clock, reset, state_ff == S_RUN, count_ff != 7'd0, "bad count")
   `RAU_ASSERT_NEXT(a_div_start, clock, reset, state_ff == S_IDLE && req.start,
      state_ff == S_RUN, "divider did not start")
endmodule

@@ hdl/rau_sequencer.sv @@
// ----------------------------------------------------------------------------
// rau_sequencer
// cross products, euclid loop and final divisions on the shared divider
// ----------------------------------------------------------------------------
`include "rational_arithmetic_unit_top_macros.svh"
module rau_sequencer #(
   parameter int OPERAND_WIDTH = 32
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  logic [2:0] req_command,
   input  logic signed [31:0] req_a_num,
   input  logic signed [31:0] req_a_den,
   input  logic signed [31:0] req_b_num,
   input  logic signed [31:0] req_b_den,
   output logic rsp_valid,
   input  logic rsp_ready,
   output logic signed [63:0] rsp_res_num,
   output logic signed [63:0] rsp_res_den,
   output logic rsp_div_zero,
   output logic rsp_is_equal,
   output logic rsp_is_less,
   output logic rsp_is_greater,
   output rau_pkg::div_req_type dreq,
   input  rau_pkg::div_rsp_type drsp
);
   import rau_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_MUL1, S_MUL2, S_COMB, S_GCD, S_GCDW, S_QN, S_QNW, S_QD, S_QDW, S_OUT
   } state_type;

   state_type state_ff;
   logic [2:0] cmd_ff;
   logic [WordWidth-1:0] an_ff, ad_ff, bn_ff, bd_ff;
   logic [WordWidth-1:0] x_ff, y_ff, num_ff, den_ff, ga_ff, gb_ff;
   logic [WordWidth-1:0] mop_a, mop_b, prod;
   logic out_valid_ff, dz_ff, eq_ff, lt_ff, gt_ff;
   logic [WordWidth-1:0] rnum_ff, rden_ff;
   // output word register, frees the datapath for the next item
   logic [WordWidth-1:0] onum_ff, oden_ff;
   logic odz_ff, oeq_ff, olt_ff, ogt_ff;
   logic out_load;
   // tracks an outstanding euclid remainder
   logic gcd_wait_ff;

   function automatic logic [WordWidth-1:0] sx(input logic [31:0] v);
      return {{(WordWidth-OPERAND_WIDTH){v[OPERAND_WIDTH-1]}}, v[OPERAND_WIDTH-1:0]};
   endfunction

   // one shared multiplier on 32-bit signed operands
   always_comb begin
      case (state_ff)
         S_MUL1: begin
            mop_a = an_ff;
            mop_b = (cmd_ff == CmdMul) ? bn_ff : bd_ff;
         end
         S_COMB: begin
            mop_a = ad_ff;
            mop_b = bd_ff;
         end
         default: begin
            mop_a = (cmd_ff == CmdAdd || cmd_ff == CmdSub || cmd_ff == CmdCmp) ? bn_ff : ad_ff;
            mop_b = (cmd_ff == CmdAdd || cmd_ff == CmdSub || cmd_ff == CmdCmp) ? ad_ff :
                    (cmd_ff == CmdDiv) ? bn_ff : bd_ff;
         end
      endcase
   end
   assign prod = WordWidth'($signed(mop_a[31:0]) * $signed(mop_b[31:0]));

   assign req_ready = (state_ff == S_IDLE);
   assign out_load = (state_ff == S_OUT) && (!out_valid_ff || rsp_ready);

   always_comb begin
      dreq.start = (state_ff == S_GCD) || (state_ff == S_QN) || (state_ff == S_QD);
      dreq.dividend = (state_ff == S_QN) ? num_ff : (state_ff == S_QD) ? den_ff : ga_ff;
      dreq.divisor  = (state_ff == S_GCD) ? gb_ff : ga_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         if (out_load) out_valid_ff <= 1'b1;
         else if (rsp_ready) out_valid_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (req_valid && req_ready) begin
                  cmd_ff <= req_command;
                  an_ff <= sx(req_a_num);
                  ad_ff <= sx(req_a_den);
                  bn_ff <= sx(req_b_num);
                  bd_ff <= sx(req_b_den);
                  dz_ff <= 1'b0; eq_ff <= 1'b0; lt_ff <= 1'b0; gt_ff <= 1'b0;
                  rnum_ff <= '0;
                  rden_ff <= WordWidth'(1);
                  state_ff <= S_MUL1;
               end
            end
            S_MUL1: begin
               x_ff <= prod;
               if (cmd_ff > CmdCmp) state_ff <= S_OUT;
               else if (cmd_ff == CmdDiv && bn_ff == '0) begin
                  dz_ff <= 1'b1;
                  state_ff <= S_OUT;
               end else state_ff <= S_MUL2;
            end
            S_MUL2: begin
               y_ff <= prod;
               state_ff <= S_COMB;
            end
            S_COMB: begin
               if (cmd_ff == CmdCmp) begin
                  eq_ff <= (x_ff == y_ff);
                  lt_ff <= $signed(x_ff) < $signed(y_ff);
                  gt_ff <= $signed(y_ff) < $signed(x_ff);
                  state_ff <= S_OUT;
               end else begin
                  // numerator and denominator of the raw result
                  num_ff <= (cmd_ff == CmdAdd) ? x_ff + y_ff :
                            (cmd_ff == CmdSub) ? x_ff - y_ff : x_ff;
                  ga_ff  <= (cmd_ff == CmdAdd) ? x_ff + y_ff :
                            (cmd_ff == CmdSub) ? x_ff - y_ff : x_ff;
                  den_ff <= (cmd_ff == CmdAdd || cmd_ff == CmdSub) ? prod : y_ff;
                  gb_ff  <= (cmd_ff == CmdAdd || cmd_ff == CmdSub) ? prod : y_ff;
                  state_ff <= S_GCDW;
               end
            end
            S_GCDW: begin
               if (gcd_wait_ff) begin
                  // euclid step result: (a, b) <= (b, a rem b)
                  if (drsp.done) begin
                     ga_ff <= gb_ff;
                     gb_ff <= drsp.rem;
                  end
               end else if (gb_ff == '0) begin
                  if (ga_ff == '0) begin
                     rnum_ff <= num_ff;
                     rden_ff <= den_ff;
                     state_ff <= S_OUT;
                  end else state_ff <= S_QN;
               end else state_ff <= S_GCD;
            end
            S_GCD: state_ff <= S_GCDW;
            S_QN: state_ff <= S_QNW;
            S_QNW: if (drsp.done) begin
               rnum_ff <= drsp.quot;
               state_ff <= S_QD;
            end
            S_QD: state_ff <= S_QDW;
            S_QDW: if (drsp.done) begin
               rden_ff <= drsp.quot;
               state_ff <= S_OUT;
            end
            S_OUT: begin
               if (out_load) begin
                  onum_ff <= rnum_ff;
                  oden_ff <= rden_ff;
                  odz_ff <= dz_ff;
                  oeq_ff <= eq_ff;
                  olt_ff <= lt_ff;
                  ogt_ff <= gt_ff;
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) gcd_wait_ff <= 1'b0;
      else if (state_ff == S_GCD) gcd_wait_ff <= 1'b1;
      else if (drsp.done) gcd_wait_ff <= 1'b0;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_res_num = onum_ff;
   assign rsp_res_den = oden_ff;
   assign rsp_div_zero = odz_ff;
   assign rsp_is_equal = oeq_ff;
   assign rsp_is_less = olt_ff;
   assign rsp_is_greater = ogt_ff;

   `RAU_ASSERT_NEXT(a_seq_hold, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_res_num) && $stable(rsp_res_den), "result word changed")
   `RAU_ASSERT_IMP(a_seq_flags, clock, reset, rsp_valid,
      $countones({rsp_is_equal, rsp_is_less, rsp_is_greater}) <= 1, "compare flags clash")
   `RAU_ASSERT_IMP(a_seq_dz, clock, reset, rsp_valid && rsp_div_zero,
      rsp_res_num == 64'sd0 && rsp_res_den == 64'sd1, "divide by zero result")
endmodule
